// File: rtl/core/cathode_sum_ellipse_selector_top_macros.svh
// Assertion macros shared by the selector modules.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef CATHODE_SUM_ELLIPSE_SELECTOR_TOP_MACROS_SVH
`define CATHODE_SUM_ELLIPSE_SELECTOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define CSES_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("cses assertion failed");

// Next-cycle implication, checked outside reset.
`define CSES_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("cses assertion failed");

`else

`define CSES_ASSERT_IMPL(lbl, ante, cons)
`define CSES_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// File: rtl/core/cses_pkg.sv
package cses_pkg;

	// Field and register widths.
	localparam int SUM_WIDTH       = 26;
	localparam int TALLY_WIDTH     = 32;
	localparam int CH_WIDTH        = 8;
	localparam int COUNT_WIDTH     = 24;
	localparam int LEN_WIDTH       = 6;
	localparam int ANGLE_WIDTH     = 16;
	localparam int INV_WIDTH       = 32;
	localparam int CFG_INDEX_WIDTH = 3;
	localparam int CFG_DATA_WIDTH  = 32;
	localparam int IN_TDATA_WIDTH  = 32;
	localparam int OUT_TDATA_WIDTH = 184;

	// Cathode channel window.
	localparam logic [CH_WIDTH-1:0] CH_LOW  = 8'd4;
	localparam logic [CH_WIDTH-1:0] CH_HIGH = 8'd11;

	// Ellipse arithmetic widths.
	localparam int FRAC_BITS   = 15;
	localparam int DIFF_WIDTH  = SUM_WIDTH + 1;
	localparam int ROT_WIDTH   = DIFF_WIDTH + ANGLE_WIDTH;
	localparam int MUL_WIDTH   = INV_WIDTH + 1;
	localparam int PROD_WIDTH  = 2 * MUL_WIDTH;
	localparam int AXIS_WIDTH  = 26;
	localparam int SQ_HI_WIDTH = 2 * AXIS_WIDTH - 1 - INV_WIDTH;
	localparam int TERM_WIDTH  = 49;

	localparam logic [AXIS_WIDTH-1:0] AXIS_CLAMP = 26'h200_0000;
	localparam logic [FRAC_BITS-1:0]  ROUND_HALF = 15'h4000;
	localparam logic [TERM_WIDTH-1:0] ONE_Q48    = 49'h1_0000_0000_0000;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_COS_ANGLE  = 3'd2,
		REG_SIN_ANGLE  = 3'd3,
		REG_INV_A_SQ   = 3'd4,
		REG_INV_B_SQ   = 3'd5,
		REG_ENTRIES    = 3'd6
	} cses_reg_t;

	// Ellipse geometry as seen by the test unit.
	typedef struct packed {
		logic [SUM_WIDTH-1:0]          center_x;
		logic [SUM_WIDTH-1:0]          center_y;
		logic signed [ANGLE_WIDTH-1:0] cos_angle;
		logic signed [ANGLE_WIDTH-1:0] sin_angle;
		logic [INV_WIDTH-1:0]          inv_a_squared;
		logic [INV_WIDTH-1:0]          inv_b_squared;
	} cses_geom_t;

	// Status returned by the test unit.
	typedef struct packed {
		logic done;
		logic sel;
	} cses_test_t;

endpackage

// File: rtl/core/cses_ellipse.sv
`include "cathode_sum_ellipse_selector_top_macros.svh"

module cses_ellipse (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [cses_pkg::SUM_WIDTH-1:0] sum_one,
	input  logic [cses_pkg::SUM_WIDTH-1:0] sum_two,
	input  cses_pkg::cses_geom_t           geom,
	output cses_pkg::cses_test_t           test
);
	import cses_pkg::*;

	typedef enum logic [8:0] {
		E_IDLE   = 9'b000000001,
		E_DIFF   = 9'b000000010,
		E_ROT    = 9'b000000100,
		E_ROUND  = 9'b000001000,
		E_SQUARE = 9'b000010000,
		E_MUL_LO = 9'b000100000,
		E_MUL_HI = 9'b001000000,
		E_TERM   = 9'b010000000,
		E_DECIDE = 9'b100000000
	} ell_state_t;

	typedef enum logic [2:0] {
		ROT_CDX  = 3'd0,
		ROT_SDY  = 3'd1,
		ROT_CDY  = 3'd2,
		ROT_SDX  = 3'd3,
		ROT_LAST = 3'd4
	} rot_step_t;

	ell_state_t st_q;
	rot_step_t  rot_cnt_q;
	logic       axis_q;
	logic       done_q;

	logic signed [DIFF_WIDTH-1:0] dx_q, dy_q;
	logic signed [ROT_WIDTH-1:0]  u_q, v_q;
	logic signed [PROD_WIDTH-1:0] prod_q;
	logic [AXIS_WIDTH-1:0]        r_q;
	logic [SQ_HI_WIDTH-1:0]       hi_q;
	logic [2*INV_WIDTH-1:0]       lp_q;
	logic [TERM_WIDTH-1:0]        ta_q, tb_q;
	logic                         sel_q;

	logic signed [MUL_WIDTH-1:0]   mul_a, mul_b;
	logic [INV_WIDTH-1:0]          inv_sel;
	logic signed [ROT_WIDTH-1:0]   rot_sel;
	logic [ROT_WIDTH-1:0]          mag;
	logic [ROT_WIDTH:0]            rsum;
	logic [ROT_WIDTH-FRAC_BITS:0]  rnd;
	logic [AXIS_WIDTH-1:0]         r_next;
	logic                          hp_big;
	logic [2*INV_WIDTH:0]          total;
	logic [TERM_WIDTH-1:0]         term_next;
	logic [TERM_WIDTH:0]           tsum;
	logic                          sel_next;

	assign inv_sel = axis_q ? geom.inv_b_squared : geom.inv_a_squared;
	assign rot_sel = axis_q ? v_q : u_q;

	// Operand selection for the one shared multiplier.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (st_q)
			E_ROT: begin
				unique case (rot_cnt_q)
					ROT_CDX: begin
						mul_a = MUL_WIDTH'(geom.cos_angle);
						mul_b = MUL_WIDTH'(dx_q);
					end
					ROT_SDY: begin
						mul_a = MUL_WIDTH'(geom.sin_angle);
						mul_b = MUL_WIDTH'(dy_q);
					end
					ROT_CDY: begin
						mul_a = MUL_WIDTH'(geom.cos_angle);
						mul_b = MUL_WIDTH'(dy_q);
					end
					ROT_SDX: begin
						mul_a = MUL_WIDTH'(geom.sin_angle);
						mul_b = MUL_WIDTH'(dx_q);
					end
					default: begin
						mul_a = '0;
						mul_b = '0;
					end
				endcase
			end
			E_SQUARE: begin
				mul_a = MUL_WIDTH'(r_q);
				mul_b = MUL_WIDTH'(r_q);
			end
			E_MUL_LO: begin
				mul_a = MUL_WIDTH'(prod_q[INV_WIDTH-1:0]);
				mul_b = MUL_WIDTH'(inv_sel);
			end
			E_MUL_HI: begin
				mul_a = MUL_WIDTH'(hi_q);
				mul_b = MUL_WIDTH'(inv_sel);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// Round the rotated coordinate half away from zero and clamp it.
	always_comb begin
		mag    = rot_sel[ROT_WIDTH-1] ? ROT_WIDTH'(-rot_sel) : ROT_WIDTH'(rot_sel);
		rsum   = {1'b0, mag} + (ROT_WIDTH+1)'(ROUND_HALF);
		rnd    = rsum[ROT_WIDTH:FRAC_BITS];
		r_next = (rnd > (ROT_WIDTH-FRAC_BITS+1)'(AXIS_CLAMP)) ? AXIS_CLAMP
		                                                       : rnd[AXIS_WIDTH-1:0];
	end

	// Combine the two partial products of the squared radius, saturate at one and compare the sum of both terms with one.
	always_comb begin
		hp_big    = |prod_q[PROD_WIDTH-1:16];
		total     = {1'b0, lp_q} + (2*INV_WIDTH+1)'({prod_q[15:0], {INV_WIDTH{1'b0}}});
		term_next = (hp_big || (total > (2*INV_WIDTH+1)'(ONE_Q48))) ? ONE_Q48
		                                                           : total[TERM_WIDTH-1:0];
		tsum      = {1'b0, ta_q} + {1'b0, tb_q};
		sel_next  = tsum < (TERM_WIDTH+1)'(ONE_Q48);
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= E_IDLE;
			rot_cnt_q <= ROT_CDX;
			axis_q    <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				E_IDLE: begin
					if (start) begin
						st_q <= E_DIFF;
					end
				end
				E_DIFF: begin
					rot_cnt_q <= ROT_CDX;
					st_q      <= E_ROT;
				end
				E_ROT: begin
					if (rot_cnt_q == ROT_LAST) begin
						axis_q <= 1'b0;
						st_q   <= E_ROUND;
					end else begin
						rot_cnt_q <= rot_step_t'(rot_cnt_q + 3'd1);
					end
				end
				E_ROUND:  st_q <= E_SQUARE;
				E_SQUARE: st_q <= E_MUL_LO;
				E_MUL_LO: st_q <= E_MUL_HI;
				E_MUL_HI: st_q <= E_TERM;
				E_TERM: begin
					if (!axis_q) begin
						axis_q <= 1'b1;
						st_q   <= E_ROUND;
					end else begin
						st_q <= E_DECIDE;
					end
				end
				E_DECIDE: begin
					done_q <= 1'b1;
					st_q   <= E_IDLE;
				end
				default: st_q <= E_IDLE;
			endcase
		end
	end

	// Datapath registers; the product register is loaded every cycle.
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		unique case (st_q)
			E_DIFF: begin
				dx_q <= $signed({1'b0, sum_one}) - $signed({1'b0, geom.center_x});
				dy_q <= $signed({1'b0, sum_two}) - $signed({1'b0, geom.center_y});
			end
			E_ROT: begin
				unique case (rot_cnt_q)
					ROT_SDY: u_q <= prod_q[ROT_WIDTH-1:0];
					ROT_CDY: u_q <= u_q + prod_q[ROT_WIDTH-1:0];
					ROT_SDX: v_q <= prod_q[ROT_WIDTH-1:0];
					ROT_LAST: v_q <= v_q - prod_q[ROT_WIDTH-1:0];
					default: ;
				endcase
			end
			E_ROUND:  r_q  <= r_next;
			E_MUL_LO: hi_q <= prod_q[INV_WIDTH +: SQ_HI_WIDTH];
			E_MUL_HI: lp_q <= prod_q[2*INV_WIDTH-1:0];
			E_TERM: begin
				if (axis_q) begin
					tb_q <= term_next;
				end else begin
					ta_q <= term_next;
				end
			end
			E_DECIDE: sel_q <= sel_next;
			default: ;
		endcase
	end

	assign test.done = done_q;
	assign test.sel  = sel_q;

	`CSES_ASSERT_IMPL(a_start_when_idle, start, st_q == E_IDLE)
	`CSES_ASSERT_IMPL(a_radius_clamped, st_q == E_SQUARE, r_q <= AXIS_CLAMP)
	`CSES_ASSERT_IMPL(a_terms_bounded, st_q == E_DECIDE, ta_q <= ONE_Q48 && tb_q <= ONE_Q48)
	`CSES_ASSERT_NEXT(a_done_single, done_q, !done_q && st_q == E_IDLE)

endmodule

// File: rtl/core/cathode_sum_ellipse_selector_top.sv
// Cathode-sum ellipse selector. Each input transaction is one readout entry; channels 4, 6, 8
// and 10 add their photon count to the first cathode sum, channels 5, 7, 9 and 11 to the
// second, both saturating. An entry that does not close an event leaves the block ready for
// the next one. The entry that closes an event (entries_per_event entries, zero meaning one)
// starts the ellipse test on one shared 33x33 multiplier: the center offsets, the rotation,
// then per axis rounding, squaring and scaling, and last the decision. No new entry is taken
// until the test is done and its result is loaded into the output register. One output
// transaction per event carries both sums, the selection flag and the four running confusion
// counters; new entries are taken while that result waits in the output register. The user
// must write configuration only while the block is idle; the block does not enforce this.
`include "cathode_sum_ellipse_selector_top_macros.svh"

module cathode_sum_ellipse_selector_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// channel [7:0], photon_count [31:8]
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [cses_pkg::IN_TDATA_WIDTH-1:0]  s_tdata,
	// truth_is_muon [0]
	input  logic                                 s_tuser,
	// cathode_one_total [25:0], cathode_two_total [51:26], selected [52],
	// true_pos_count [84:53], false_pos_count [116:85], false_neg_count [148:117],
	// true_neg_count [180:149], zero fill [183:181]
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [cses_pkg::OUT_TDATA_WIDTH-1:0] m_tdata,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [cses_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
	input  logic [cses_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);
	import cses_pkg::*;

	typedef enum logic [2:0] {
		TOP_IDLE = 3'b001,
		TOP_TEST = 3'b010,
		TOP_EMIT = 3'b100
	} top_state_t;

	top_state_t st_q;

	cses_geom_t           geom_q;
	logic [LEN_WIDTH-1:0] entries_q;

	logic [SUM_WIDTH-1:0]   acc_one_q, acc_two_q;
	logic [LEN_WIDTH-1:0]   pos_q;
	logic                   muon_q;
	logic [TALLY_WIDTH-1:0] tp_q, fp_q, fn_q, tn_q;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_WIDTH-1:0] m_tdata_q;

	logic [CH_WIDTH-1:0]    in_chan;
	logic [COUNT_WIDTH-1:0] in_count;
	logic                   in_acc;
	logic                   in_window, add_one, add_two, closes;
	logic [SUM_WIDTH:0]     sum_one_ext, sum_two_ext;
	logic [SUM_WIDTH-1:0]   sum_one_sat, sum_two_sat;
	logic [LEN_WIDTH-1:0]   len, pos_inc;
	logic                   emit_load;
	logic [TALLY_WIDTH-1:0] tp_next, fp_next, fn_next, tn_next, tally_total;
	cses_test_t             test;

	assign cfg_ready = 1'b1;
	assign s_tready  = (st_q == TOP_IDLE);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	assign in_chan  = s_tdata[CH_WIDTH-1:0];
	assign in_count = s_tdata[CH_WIDTH +: COUNT_WIDTH];
	assign in_acc   = s_tvalid && s_tready;

	// Cathode routing, saturating sums and event length.
	always_comb begin
		in_window   = (in_chan >= CH_LOW) && (in_chan <= CH_HIGH);
		add_one     = in_window && !in_chan[0];
		add_two     = in_window && in_chan[0];
		sum_one_ext = {1'b0, acc_one_q} + (SUM_WIDTH+1)'(in_count);
		sum_two_ext = {1'b0, acc_two_q} + (SUM_WIDTH+1)'(in_count);
		sum_one_sat = sum_one_ext[SUM_WIDTH] ? '1 : sum_one_ext[SUM_WIDTH-1:0];
		sum_two_sat = sum_two_ext[SUM_WIDTH] ? '1 : sum_two_ext[SUM_WIDTH-1:0];
		len         = (entries_q == '0) ? LEN_WIDTH'(1) : entries_q;
		pos_inc     = pos_q + LEN_WIDTH'(1);
		closes      = pos_inc >= len;
	end

	// Confusion counters after this event.
	always_comb begin
		emit_load = (st_q == TOP_EMIT) && (!m_tvalid_q || m_tready);
		tp_next   = tp_q + TALLY_WIDTH'(test.sel && muon_q);
		fp_next   = fp_q + TALLY_WIDTH'(test.sel && !muon_q);
		fn_next   = fn_q + TALLY_WIDTH'(!test.sel && muon_q);
		tn_next   = tn_q + TALLY_WIDTH'(!test.sel && !muon_q);
		tally_total = tp_q + fp_q + fn_q + tn_q;
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			geom_q.center_x      <= '0;
			geom_q.center_y      <= '0;
			geom_q.cos_angle     <= 16'sd32767;
			geom_q.sin_angle     <= '0;
			geom_q.inv_a_squared <= '0;
			geom_q.inv_b_squared <= '0;
			entries_q            <= 6'd20;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cses_reg_t'(cfg_index))
				REG_CENTER_X:  geom_q.center_x      <= cfg_data[SUM_WIDTH-1:0];
				REG_CENTER_Y:  geom_q.center_y      <= cfg_data[SUM_WIDTH-1:0];
				REG_COS_ANGLE: geom_q.cos_angle     <= cfg_data[ANGLE_WIDTH-1:0];
				REG_SIN_ANGLE: geom_q.sin_angle     <= cfg_data[ANGLE_WIDTH-1:0];
				REG_INV_A_SQ:  geom_q.inv_a_squared <= cfg_data[INV_WIDTH-1:0];
				REG_INV_B_SQ:  geom_q.inv_b_squared <= cfg_data[INV_WIDTH-1:0];
				REG_ENTRIES:   entries_q            <= cfg_data[LEN_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Event control, accumulators and tallies.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= TOP_IDLE;
			acc_one_q  <= '0;
			acc_two_q  <= '0;
			pos_q      <= '0;
			tp_q       <= '0;
			fp_q       <= '0;
			fn_q       <= '0;
			tn_q       <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// The result register fills on emit and drains when the transaction is taken.
			if (emit_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (st_q)
				TOP_IDLE: begin
					if (in_acc) begin
						if (add_one) begin
							acc_one_q <= sum_one_sat;
						end
						if (add_two) begin
							acc_two_q <= sum_two_sat;
						end
						pos_q <= closes ? '0 : pos_inc;
						if (closes) begin
							st_q <= TOP_TEST;
						end
					end
				end
				TOP_TEST: begin
					if (test.done) begin
						st_q <= TOP_EMIT;
					end
				end
				TOP_EMIT: begin
					if (emit_load) begin
						tp_q      <= tp_next;
						fp_q      <= fp_next;
						fn_q      <= fn_next;
						tn_q      <= tn_next;
						acc_one_q <= '0;
						acc_two_q <= '0;
						st_q      <= TOP_IDLE;
					end
				end
				default: st_q <= TOP_IDLE;
			endcase
		end
	end

	// Truth flag of the closing entry and the output payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			muon_q <= s_tuser;
		end
		if (emit_load) begin
			m_tdata_q <= {3'b000, tn_next, fn_next, fp_next, tp_next, test.sel,
			              acc_two_q, acc_one_q};
		end
	end

	cses_ellipse u_ellipse (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (in_acc && closes),
		.sum_one (acc_one_q),
		.sum_two (acc_two_q),
		.geom    (geom_q),
		.test    (test)
	);

	`CSES_ASSERT_NEXT(a_close_starts_test, in_acc && closes, st_q == TOP_TEST)
	`CSES_ASSERT_IMPL(a_done_only_in_test, test.done, st_q == TOP_TEST)
	`CSES_ASSERT_NEXT(a_emit_counts_one, emit_load, tally_total == $past(tally_total) + 32'd1)
	`CSES_ASSERT_NEXT(a_emit_clears_sums, emit_load, acc_one_q == '0 && acc_two_q == '0)

endmodule
